// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the comment stripper modules.
// Each use expects signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define CS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent holds.
`define CS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/cstrip_pkg.sv =====
// ----------------------------------------------------------------------------
// cstrip_pkg
// Shared types, character codes and helpers of the comment stripper.
// ----------------------------------------------------------------------------
package cstrip_pkg;

	localparam int unsigned SHOWN_W = 16;
	localparam int unsigned MAX_EMIT = 4;

	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_NL    = 8'h0A;

	// Bytes produced by one input word, in output order, and how many are valid.
	typedef struct packed {
		logic [MAX_EMIT-1:0][7:0] bytes;
		logic [2:0]               cnt;
	} cs_emit_t;

	function automatic cs_emit_t push_byte(cs_emit_t e, logic [7:0] b);
		if (e.cnt < 3'(MAX_EMIT)) begin
			e.bytes[e.cnt[1:0]] = b;
			e.cnt = e.cnt + 3'd1;
		end
		return e;
	endfunction

endpackage

// ===== rtl/core/cstrip_parse.sv =====
// ----------------------------------------------------------------------------
// cstrip_parse
// Parse state and comment tally, with the next-state logic that decides which
// bytes one input word produces.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cstrip_parse import cstrip_pkg::*; #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic [7:0]         in_byte,
	input  logic               end_of_stream,
	output cs_emit_t           emit,
	output logic [SHOWN_W-1:0] comments_seen
);

	typedef enum logic [3:0] {
		M_NORMAL = 4'd0,
		M_SLASH  = 4'd1,
		M_LT     = 4'd2,
		M_LTB    = 4'd3,
		M_LTBD   = 4'd4,
		M_LINE   = 4'd5,
		M_BLOCK  = 4'd6,
		M_BSTAR  = 4'd7,
		M_MARK   = 4'd8,
		M_DASH1  = 4'd9,
		M_DASH2  = 4'd10
	} mode_t;

	mode_t                 mode_q, mode_n;
	logic [COUNT_BITS-1:0] tally_q, tally_n, tally_inc;
	cs_emit_t              em;

	function automatic mode_t held_mode(logic [7:0] c);
		if (c == CH_SLASH) return M_SLASH;
		else if (c == CH_LT) return M_LT;
		else return M_NORMAL;
	endfunction

	// Bytes of a possible opener that are still held back.
	function automatic cs_emit_t flush_held(cs_emit_t e, mode_t m);
		case (m)
			M_SLASH: begin
				e = push_byte(e, CH_SLASH);
			end
			M_LT: begin
				e = push_byte(e, CH_LT);
			end
			M_LTB: begin
				e = push_byte(e, CH_LT);
				e = push_byte(e, CH_BANG);
			end
			M_LTBD: begin
				e = push_byte(e, CH_LT);
				e = push_byte(e, CH_BANG);
				e = push_byte(e, CH_DASH);
			end
			default: begin
			end
		endcase
		return e;
	endfunction

	function automatic cs_emit_t take_normal(cs_emit_t e, logic [7:0] c);
		if (c != CH_SLASH && c != CH_LT) e = push_byte(e, c);
		return e;
	endfunction

	assign tally_inc = (&tally_q) ? tally_q : tally_q + COUNT_BITS'(1);

	always_comb begin
		em = '0;
		mode_n = mode_q;
		tally_n = tally_q;
		case (mode_q)
			M_SLASH: begin
				if (in_byte == CH_SLASH) begin
					tally_n = tally_inc;
					mode_n = M_LINE;
				end else if (in_byte == CH_STAR) begin
					tally_n = tally_inc;
					mode_n = M_BLOCK;
				end else begin
					em = take_normal(flush_held(em, mode_q), in_byte);
					mode_n = held_mode(in_byte);
				end
			end
			M_LT: begin
				if (in_byte == CH_BANG) begin
					mode_n = M_LTB;
				end else begin
					em = take_normal(flush_held(em, mode_q), in_byte);
					mode_n = held_mode(in_byte);
				end
			end
			M_LTB: begin
				if (in_byte == CH_DASH) begin
					mode_n = M_LTBD;
				end else begin
					em = take_normal(flush_held(em, mode_q), in_byte);
					mode_n = held_mode(in_byte);
				end
			end
			M_LTBD: begin
				if (in_byte == CH_DASH) begin
					tally_n = tally_inc;
					mode_n = M_MARK;
				end else begin
					em = take_normal(flush_held(em, mode_q), in_byte);
					mode_n = held_mode(in_byte);
				end
			end
			M_LINE: begin
				if (in_byte == CH_NL) begin
					em = push_byte(em, CH_NL);
					mode_n = M_NORMAL;
				end
			end
			M_BLOCK: begin
				if (in_byte == CH_STAR) mode_n = M_BSTAR;
			end
			M_BSTAR: begin
				if (in_byte == CH_SLASH) mode_n = M_NORMAL;
				else if (in_byte != CH_STAR) mode_n = M_BLOCK;
			end
			M_MARK: begin
				if (in_byte == CH_DASH) mode_n = M_DASH1;
			end
			M_DASH1: begin
				mode_n = (in_byte == CH_DASH) ? M_DASH2 : M_MARK;
			end
			M_DASH2: begin
				if (in_byte == CH_GT) mode_n = M_NORMAL;
				else if (in_byte != CH_DASH) mode_n = M_MARK;
			end
			default: begin
				em = take_normal(em, in_byte);
				mode_n = held_mode(in_byte);
			end
		endcase
		// End of stream releases whatever is still held and restarts parsing.
		if (end_of_stream) begin
			em = flush_held(em, mode_n);
			mode_n = M_NORMAL;
		end
	end

	assign emit = em;

	generate
		if (COUNT_BITS > SHOWN_W) begin : g_clamp
			assign comments_seen = (|tally_n[COUNT_BITS-1:SHOWN_W]) ? '1
				: tally_n[SHOWN_W-1:0];
		end else begin : g_extend
			assign comments_seen = SHOWN_W'(tally_n);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			tally_q <= '0;
		end else if (advance) begin
			mode_q <= mode_n;
			tally_q <= tally_n;
		end
	end

	`CS_ASSERT_NEXT(a_eos_resets_mode, advance && end_of_stream, mode_q == M_NORMAL,
		"parse mode not normal after end of stream")
	`CS_ASSERT_NEXT(a_tally_monotonic, 1'b1, tally_q >= $past(tally_q),
		"comment tally decreased")
	`CS_ASSERT(a_emit_bound, !advance || emit.cnt <= 3'(MAX_EMIT),
		"more bytes produced than the result buffer holds")

endmodule

// ===== rtl/core/cstrip_outbuf.sv =====
// ----------------------------------------------------------------------------
// cstrip_outbuf
// Result register: holds the bytes produced by one input word and hands them
// to the output stream one word per cycle while m_tready is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cstrip_outbuf import cstrip_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  cs_emit_t           emit,
	input  logic [SHOWN_W-1:0] comments_seen,
	output logic               res_free,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [23:0]        m_tdata,   // out_byte [7:0], comments_seen [23:8]
	output logic               m_tlast    // last_of_run
);

	logic                     valid_q;
	logic [MAX_EMIT-1:0][7:0] bytes_q;
	logic [2:0]               cnt_q;
	logic [1:0]               idx_q;
	logic [SHOWN_W-1:0]       shown_q;
	logic                     pop, at_last;

	assign pop = valid_q && m_tready;
	assign at_last = ({1'b0, idx_q} + 3'd1) == cnt_q;
	assign res_free = !valid_q || (pop && at_last);

	assign m_tvalid = valid_q;
	assign m_tdata = {shown_q, bytes_q[idx_q]};
	assign m_tlast = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			cnt_q <= emit.cnt;
			idx_q <= '0;
		end else if (pop) begin
			if (at_last) valid_q <= 1'b0;
			else idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= emit.bytes;
			shown_q <= comments_seen;
		end
	end

	`CS_ASSERT(a_load_when_free, !load || res_free, "result register overwritten")
	`CS_ASSERT(a_idx_in_range, !valid_q || ({1'b0, idx_q} < cnt_q),
		"output index beyond stored byte count")
	`CS_ASSERT_NEXT(a_run_continues, pop && !at_last, valid_q,
		"run ended before its last word")

endmodule

// ===== rtl/core/comment_stripper_unit.sv =====
// An accepted byte is registered in the input stage, its output bytes in the
// result register. Throughput: one input word per cycle while the result register
// is free; an input with k output words holds the input side while they drain.
// Reset (arst_n low) clears the parse mode to normal text, the comment tally to
// zero and all valid flags; no output word is pending after reset.
// ----------------------------------------------------------------------------
// comment_stripper_unit
// Streaming remover of line, block and markup comments from a byte stream.
// ----------------------------------------------------------------------------
module comment_stripper_unit import cstrip_pkg::*; #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte [7:0]
	input  logic        s_tlast,   // end_of_stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_byte [7:0], comments_seen [23:8]
	output logic        m_tlast    // last_of_run
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               eos_s1;
	logic               res_free, advance;
	cs_emit_t           emit;
	logic [SHOWN_W-1:0] shown;

	assign advance = valid_s1 && res_free;
	assign s_tready = !valid_s1 || res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eos_s1 <= s_tlast;
		end
	end

	cstrip_parse #(
		.COUNT_BITS(COUNT_BITS)
	) u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.in_byte      (byte_s1),
		.end_of_stream(eos_s1),
		.emit         (emit),
		.comments_seen(shown)
	);

	cstrip_outbuf u_outbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && (emit.cnt != 3'd0)),
		.emit         (emit),
		.comments_seen(shown),
		.res_free     (res_free),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast)
	);

endmodule
